// ===== rtl/lcdldr_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdldr_pkg: shared types and constants
// Result entry layout, output queue push group, register indexes and the
// fixed byte codes of the character display refresh block.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdldr_pkg;

   localparam logic [7:0] CURSOR_CMD = 8'h80;
   localparam logic [7:0] SPACE_CHAR = 8'h20;

   // register indexes on the configuration port
   localparam logic REG_ROW0 = 1'b0;
   localparam logic REG_ROW1 = 1'b1;

   typedef struct packed {
      logic       is_command;
      logic [7:0] out_byte;
      logic       last;
   } rsp_entry_type;

   // up to two results handed to the output queue in one cycle
   typedef struct packed {
      logic [1:0]    count;
      rsp_entry_type first;
      rsp_entry_type second;
   } q_push_type;

endpackage

`default_nettype wire

// ===== rtl/lcd_line_diff_refresh.sv =====
// ----------------------------------------------------------------------------
// lcd_line_diff_refresh: dirty-run refresh of a character display
// Compares each incoming character with a shadow copy of the screen and
// emits a cursor command at the start of each run of changed characters,
// followed by the changed characters themselves.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+-----------------------------------
//   req_    | in  | tvalid / tready        | tuser kind, tdata row + char_code
//   rsp_    | out | tvalid / tready        | tuser is_command, tdata out_byte,
//           |     |                        | tlast last
//   csr_    | in  | psel/penable/pwrite    | row0/row1 base addresses
//
// An item is accepted in any cycle in which stage one is empty or retires.
// Each item waits in stage one for its shadow read data, then its zero, one
// or two results land in a two-entry output queue; the first result is
// offered from the queue register once stage one has retired the item.
// Unchanged characters give no result and characters inside a run give
// one; a run start puts two results on the single result port.
// After reset the shadow reads as all zeros through per-entry known bits, so
// no clearing pass is needed; items are accepted from the first cycle.
// A stall on the result side fills the queue and then holds stage one.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_line_diff_refresh #(
   parameter int ROWS = 2,
   parameter int COLS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input item
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [0] row, [8:1] char_code, [15:9] zero
   input  logic        req_tuser,   // [0] kind
   // result item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tuser,   // [0] is_command
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lcdldr_pkg::*;

   localparam int DEPTH = ROWS * COLS;
   localparam int SW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
   localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);
   localparam logic          ROW_LAST = 1'(ROWS - 1);

   // ---------------------------------------------------------------- config
   logic [6:0] row0_ff;
   logic [6:0] row1_ff;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff <= 7'd0;
         row1_ff <= 7'd64;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_ROW0: row0_ff <= csr_pwdata[6:0];
            REG_ROW1: row1_ff <= csr_pwdata[6:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_ROW0: csr_prdata = {25'd0, row0_ff};
         REG_ROW1: csr_prdata = {25'd0, row1_ff};
         default:  csr_prdata = 32'd0;
      endcase
   end

   // -------------------------------------------------------- input decoding
   logic          in_kind;
   logic          in_row;
   logic [7:0]    in_code;
   logic          row_ok;
   logic          req_xfer;
   logic          in_paint;
   logic          load;

   assign in_kind  = req_tuser;
   assign in_row   = req_tdata[0];
   assign in_code  = req_tdata[8:1];
   // rows past the display are dropped without touching any state
   assign row_ok   = (ROWS > 1) || !in_row;
   assign req_xfer = req_tvalid && req_tready;
   assign in_paint = req_xfer && !in_kind && row_ok;
   assign load     = req_xfer && (in_kind || row_ok);

   // ------------------------------------------- stage zero: column tracking
   logic [CW-1:0] col_ff;
   logic          txt_end_ff;
   logic          s0_ended;
   logic [7:0]    s0_ch;
   logic          s0_eol;
   logic [SW-1:0] s0_slot;

   assign s0_ended = txt_end_ff || (in_code == 8'h00);
   assign s0_ch    = s0_ended ? SPACE_CHAR : in_code;
   assign s0_eol   = (col_ff == COL_LAST);
   assign s0_slot  = (in_row ? SW'(COLS) : SW'(0)) + SW'(col_ff);

   // advance the column and the end-of-text flag on every painted character
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         txt_end_ff <= 1'b0;
      end else if (in_paint) begin
         col_ff     <= s0_eol ? '0 : col_ff + 1'b1;
         txt_end_ff <= s0_eol ? 1'b0 : s0_ended;
      end
   end

   // ------------------------------------------------- stage one: compare
   logic          s1_vld_ff;
   logic          s1_inval_ff;
   logic          s1_row_ff;
   logic [CW-1:0] s1_col_ff;
   logic [7:0]    s1_ch_ff;
   logic [SW-1:0] s1_slot_ff;
   logic          s1_eol_ff;
   logic          s1_fwd_ff;
   logic [7:0]    s1_fwd_ch_ff;
   logic          shv_ff;
   logic          run_ff;

   logic [7:0]    sh_data;
   logic [7:0]    old_ch;
   logic          differs;
   logic [1:0]    n_res;
   logic [1:0]    q_room;
   logic          s1_retire;
   logic          fwd_hit;
   logic [6:0]    row_addr;
   q_push_type    push;
   rsp_entry_type head;

   // the shadow write of the retiring item lands at the same edge as the
   // read of the next one: hand its byte over directly on a slot match
   assign fwd_hit = s1_vld_ff && !s1_inval_ff && s1_retire && (s1_slot_ff == s0_slot);

   assign old_ch  = s1_fwd_ff ? s1_fwd_ch_ff : sh_data;
   assign differs = !shv_ff || (s1_ch_ff != old_ch);

   always_comb begin
      if (s1_inval_ff || !differs) begin
         n_res = 2'd0;
      end else if (run_ff) begin
         n_res = 2'd1;
      end else begin
         n_res = 2'd2;
      end
   end

   assign s1_retire  = s1_vld_ff && (n_res <= q_room);
   assign req_tready = !s1_vld_ff || s1_retire;

   always_ff @(posedge clock) begin
      if (load) begin
         s1_inval_ff  <= in_kind;
         s1_row_ff    <= in_row;
         s1_col_ff    <= col_ff;
         s1_ch_ff     <= s0_ch;
         s1_slot_ff   <= s0_slot;
         s1_eol_ff    <= s0_eol;
         s1_fwd_ff    <= fwd_hit;
         s1_fwd_ch_ff <= s1_ch_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         shv_ff    <= 1'b0;
         run_ff    <= 1'b0;
      end else begin
         if (load) begin
            s1_vld_ff <= 1'b1;
         end else if (s1_retire) begin
            s1_vld_ff <= 1'b0;
         end
         if (s1_retire) begin
            if (s1_inval_ff) begin
               // invalidate: drop validity only, keep the run state
               shv_ff <= 1'b0;
            end else begin
               // a changed character opens or extends a run; a match or a line end closes it
               run_ff <= s1_eol_ff ? 1'b0 : differs;
               if (s1_eol_ff && (s1_row_ff == ROW_LAST)) begin
                  shv_ff <= 1'b1;
               end
            end
         end
      end
   end

   lcdldr_shadow #(
      .DEPTH (DEPTH)
   ) u_shadow (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (in_paint),
      .rd_addr (s0_slot),
      .rd_data (sh_data),
      .wr_en   (s1_retire && !s1_inval_ff),
      .wr_addr (s1_slot_ff),
      .wr_data (s1_ch_ff)
   );

   // ---------------------------------------------------- result assembly
   assign row_addr = s1_row_ff ? row1_ff : row0_ff;

   always_comb begin
      push.count             = s1_retire ? n_res : 2'd0;
      push.second.is_command = 1'b0;
      push.second.out_byte   = s1_ch_ff;
      push.second.last       = 1'b1;
      if (n_res == 2'd2) begin
         push.first.is_command = 1'b1;
         push.first.out_byte   = CURSOR_CMD | {1'b0, row_addr} | 8'(s1_col_ff);
         push.first.last       = 1'b0;
      end else begin
         push.first = push.second;
      end
   end

   lcdldr_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (q_room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .head       (head)
   );

   assign rsp_tdata = head.out_byte;
   assign rsp_tuser = head.is_command;
   assign rsp_tlast = head.last;

   // ------------------------------------------------------------ checks
   // cursor commands always carry the set-address opcode bit
   a_cmd_opcode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[7])
      else $error("cursor command without opcode bit");

   // a cursor command never closes an item's results
   a_cmd_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tlast)
      else $error("cursor command marked last");

   // the character of a run start is queued together with its command
   a_cmd_then_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser |=> rsp_tvalid && !rsp_tuser)
      else $error("cursor command not followed by its character");

   // the column never runs past the last one
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= COL_LAST)
      else $error("column out of range");

endmodule

`default_nettype wire

// ===== rtl/lcdldr_shadow.sv =====
// ----------------------------------------------------------------------------
// lcdldr_shadow: shadow copy of the screen
// One write and one registered read per cycle; per-entry known bits make an
// entry that was never written read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdldr_shadow #(
   parameter int  DEPTH = 32,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data
);
   logic [7:0]       mem [DEPTH];
   logic [DEPTH-1:0] known_ff;
   logic [7:0]       rd_data_ff;
   logic             rd_known_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff    <= '0;
         rd_known_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            known_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_known_ff <= known_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_known_ff ? rd_data_ff : 8'h00;

endmodule

`default_nettype wire

// ===== rtl/lcdldr_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// lcdldr_rsp_queue: two-entry result queue
// Takes up to two results per cycle as room allows and presents one per cycle
// on the result channel while it is ready; reports how many entries are free for the next push.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdldr_rsp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  lcdldr_pkg::q_push_type    push,
   output logic [1:0]                room,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output lcdldr_pkg::rsp_entry_type head
);
   import lcdldr_pkg::*;

   rsp_entry_type q0_ff, q0_in;
   rsp_entry_type q1_ff, q1_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic [1:0]    base;
   logic          pop;

   assign pop  = (cnt_ff != 2'd0) && rsp_tready;
   assign base = cnt_ff - {1'b0, pop};
   assign room = 2'd2 - base;

   always_comb begin
      q0_in = pop ? q1_ff : q0_ff;
      q1_in = q1_ff;
      unique case (base)
         2'd0: begin
            q0_in = push.first;
            q1_in = push.second;
         end
         2'd1: begin
            q1_in = push.first;
         end
         default: begin
         end
      endcase
      cnt_in = base + push.count;
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign head       = q0_ff;

endmodule

`default_nettype wire
